### rtl/short_name_path_validator_unit_macros.svh
// ---------------------------------------------------------------------------
// short name path validator macros
// assertion shorthands shared by the validator rtl
// ---------------------------------------------------------------------------
`ifndef SHORT_NAME_PATH_VALIDATOR_UNIT_MACROS_SVH
`define SHORT_NAME_PATH_VALIDATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SNPV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snpv assertion failed");

// next-cycle implication, disabled during reset
`define SNPV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snpv assertion failed");

`endif

### rtl/snpv_pkg.sv
// ---------------------------------------------------------------------------
// snpv_pkg
// parser phase codes, character codes, limits and name character check of the path validator
// ---------------------------------------------------------------------------
package snpv_pkg;

    typedef logic [2:0] phase_t;

    localparam phase_t PH_START   = 3'd0;
    localparam phase_t PH_DIGIT   = 3'd1;
    localparam phase_t PH_COLON   = 3'd2;
    localparam phase_t PH_LOGICAL = 3'd3;
    localparam phase_t PH_ROOT    = 3'd4;
    localparam phase_t PH_COMP    = 3'd5;
    localparam phase_t PH_SEP     = 3'd6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [3:0] MAX_BASE  = 4'd8;
    localparam logic [2:0] MAX_EXT   = 3'd3;
    localparam logic [3:0] MAX_DRIVE = 4'd9;
    localparam logic [3:0] DEVICE_LIMIT_RST = 4'd10;

    function automatic logic name_char_ok(input logic [7:0] c);
        logic ok;
        ok = (c inside {[8'h41:8'h5A], [CH_ZERO:CH_NINE]}) ||
             (c == 8'h5F) || (c == 8'h2D) || (c == 8'h24) || (c == 8'h7E);
        return ok;
    endfunction

endpackage

### rtl/short_name_path_validator_unit.sv
// ---------------------------------------------------------------------------
// short_name_path_validator_unit
// checks a byte stream of paths against short 8.3 name rules
// ---------------------------------------------------------------------------
// usage
//   s_axis: one path byte per word in tdata[7:0]; a zero byte ends the path
//   m_axis: one verdict word per terminated path, tdata[0] = path valid
//   cfg_we / cfg_wdata: writes the device limit (drive digit must be below it)
// throughput
//   one byte per clock, terminators too unless a held verdict blocks them; the
//   parser state update is a short combinational step between state registers and result
// verdict timing
//   the verdict of a path is registered and appears on m_axis in the cycle after its zero byte
// reset
//   parser returns to the path start phase, no verdict pending, device
//   limit back to 10
// stalls
//   a held verdict only blocks the next zero byte; ordinary path bytes keep
//   flowing while m_axis_tready is low, so the verdict register acts as the
//   skid stage between the two sides
// ---------------------------------------------------------------------------
`include "short_name_path_validator_unit_macros.svh"

module short_name_path_validator_unit
    import snpv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,          // device_limit
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,       // [7:0] path_char
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata        // [0] path_valid, [7:1] zero
);

    // configuration
    logic [3:0] device_limit_reg;

    // parser state
    phase_t     phase_reg, phase_next;
    logic [3:0] base_count_reg, base_count_next;
    logic [2:0] ext_count_reg, ext_count_next;
    logic       in_ext_reg, in_ext_next;
    logic       failed_reg, failed_next;
    logic [3:0] drive_digit_reg, drive_digit_next;

    // verdict register
    logic       out_valid_reg, out_valid_next;
    logic       out_data_reg, out_data_next;

    logic [7:0] c;
    logic       is_term;
    logic       in_acc;

    // component step inputs and outputs
    logic       new_comp;
    logic [3:0] cb;
    logic [2:0] ce;
    logic       ci;
    logic [3:0] sb;
    logic [2:0] se;
    logic       si;
    logic       sfail;
    logic [3:0] base_inc;
    logic [2:0] ext_inc;
    logic       done_ok;
    logic       verdict;

    assign c       = s_axis_tdata;
    assign is_term = (c == CH_NUL);

    // only a terminator needs the verdict register free
    assign s_axis_tready = !out_valid_reg || m_axis_tready || !is_term;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};

    // current component is complete: nonempty base, extension nonempty if dotted
    assign done_ok = (base_count_reg != 4'd0) && (!in_ext_reg || (ext_count_reg != 3'd0));

    // a component starts fresh after start, logical prefix, root and separator
    always_comb
    begin
        case (phase_reg)
            PH_START, PH_LOGICAL, PH_ROOT, PH_SEP: new_comp = 1'b1;
            default:                               new_comp = 1'b0;
        endcase
    end

    assign cb = new_comp ? 4'd0 : base_count_reg;
    assign ce = new_comp ? 3'd0 : ext_count_reg;
    assign ci = new_comp ? 1'b0 : in_ext_reg;

    assign base_inc = cb + 4'd1;
    assign ext_inc  = ce + 3'd1;

    // one character fed into the component
    always_comb
    begin
        sb    = cb;
        se    = ce;
        si    = ci;
        sfail = 1'b0;
        if (c == CH_DOT)
        begin
            if (ci || (cb == 4'd0))
                sfail = 1'b1;
            else
                si = 1'b1;
        end
        else if (!name_char_ok(c))
        begin
            sfail = 1'b1;
        end
        else if (ci)
        begin
            se    = ext_inc;
            sfail = (ext_inc > MAX_EXT);
        end
        else
        begin
            sb    = base_inc;
            sfail = (base_inc > MAX_BASE);
        end
    end

    // verdict for the path closed by the terminator
    always_comb
    begin
        if (failed_reg)
            verdict = 1'b0;
        else
        begin
            case (phase_reg)
                PH_START, PH_LOGICAL, PH_ROOT: verdict = 1'b1;
                PH_DIGIT, PH_COMP:             verdict = done_ok;
                default:                       verdict = 1'b0;
            endcase
        end
    end

    // parser transition
    always_comb
    begin
        phase_next       = phase_reg;
        base_count_next  = base_count_reg;
        ext_count_next   = ext_count_reg;
        in_ext_next      = in_ext_reg;
        failed_next      = failed_reg;
        drive_digit_next = drive_digit_reg;

        if (in_acc && is_term)
        begin
            phase_next      = PH_START;
            base_count_next = 4'd0;
            ext_count_next  = 3'd0;
            in_ext_next     = 1'b0;
            failed_next     = 1'b0;
        end
        else if (in_acc && !failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    // first byte of a path, may be a drive digit
                    drive_digit_next = 4'(c - CH_ZERO);
                    if (c == CH_SLASH)
                        phase_next = PH_ROOT;
                    else
                    begin
                        base_count_next = sb;
                        ext_count_next  = se;
                        in_ext_next     = si;
                        failed_next     = sfail;
                        phase_next      = (c >= CH_ZERO && c <= CH_NINE) ? PH_DIGIT : PH_COMP;
                    end
                end
                PH_DIGIT:
                begin
                    if (c == CH_COLON)
                        phase_next = PH_COLON;
                    else if (c == CH_SLASH)
                        phase_next = PH_SEP;
                    else
                    begin
                        base_count_next = sb;
                        ext_count_next  = se;
                        in_ext_next     = si;
                        failed_next     = sfail;
                        phase_next      = PH_COMP;
                    end
                end
                PH_COLON:
                begin
                    if (c == CH_SLASH)
                    begin
                        failed_next = !((drive_digit_reg < device_limit_reg) &&
                                        (drive_digit_reg <= MAX_DRIVE));
                        phase_next  = PH_LOGICAL;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_LOGICAL:
                begin
                    if (c == CH_SLASH)
                        phase_next = PH_ROOT;
                    else
                    begin
                        base_count_next = sb;
                        ext_count_next  = se;
                        in_ext_next     = si;
                        failed_next     = sfail;
                        phase_next      = PH_COMP;
                    end
                end
                PH_ROOT, PH_SEP:
                begin
                    // empty component: doubled slash or slash after root
                    if (c == CH_SLASH)
                        failed_next = 1'b1;
                    else
                    begin
                        base_count_next = sb;
                        ext_count_next  = se;
                        in_ext_next     = si;
                        failed_next     = sfail;
                        phase_next      = PH_COMP;
                    end
                end
                PH_COMP:
                begin
                    if (c == CH_SLASH)
                    begin
                        failed_next = !done_ok;
                        phase_next  = PH_SEP;
                    end
                    else
                    begin
                        base_count_next = sb;
                        ext_count_next  = se;
                        in_ext_next     = si;
                        failed_next     = sfail;
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    // verdict register, loaded on a terminator, drained by the receiver
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_acc && is_term)
        begin
            out_valid_next = 1'b1;
            out_data_next  = verdict;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_limit_reg <= DEVICE_LIMIT_RST;
            phase_reg        <= PH_START;
            base_count_reg   <= 4'd0;
            ext_count_reg    <= 3'd0;
            in_ext_reg       <= 1'b0;
            failed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                device_limit_reg <= cfg_wdata;
            phase_reg      <= phase_next;
            base_count_reg <= base_count_next;
            ext_count_reg  <= ext_count_next;
            in_ext_reg     <= in_ext_next;
            failed_reg     <= failed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        drive_digit_reg <= drive_digit_next;
        out_data_reg    <= out_data_next;
    end

    // a terminator always leaves a verdict behind
    `SNPV_ASSERT_NEXT(a_term_gives_verdict, clk, rst_n, in_acc && is_term, out_valid_reg)

    // ordinary bytes never invent a verdict
    `SNPV_ASSERT_NEXT(a_no_spurious_verdict, clk, rst_n,
                      in_acc && !is_term && !out_valid_reg, !out_valid_reg)

    // a rejected path stays rejected until its terminator
    `SNPV_ASSERT_NEXT(a_failed_sticky, clk, rst_n,
                      failed_reg && !(in_acc && is_term), failed_reg)

    // the parser restarts cleanly after every terminator
    `SNPV_ASSERT_NEXT(a_restart, clk, rst_n, in_acc && is_term,
                      (phase_reg == PH_START) && !failed_reg && (base_count_reg == 4'd0))

    // extension characters only count after a dot
    `SNPV_ASSERT_IMP(a_ext_after_dot, clk, rst_n, ext_count_reg != 3'd0, in_ext_reg)

endmodule

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the short 8.3 path validator: feeds whole paths a
// byte at a time, predicts each verdict from its own copy of the parser or takes
// it from the directed table, and compares every verdict word that leaves the block
// ---------------------------------------------------------------------------
module tb
    import snpv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] char_t;

    // where the verdict of a directed path comes from
    typedef enum int
    {
        VERDICT_PREDICT,
        VERDICT_ACCEPT,
        VERDICT_REJECT
    } verdict_src_t;

    typedef struct
    {
        logic [3:0]   limit;
        string        text;
        verdict_src_t how;
    } stim_row_t;

    localparam string NAME_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-$~";
    localparam int    RANDOM_BYTES_PER_PHASE = 95;
    localparam int    VERDICTS_PER_PHASE = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;      // [7:0] path_char
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;             // [0] path_valid, [7:1] zero

    // directed paths: extremes, every special case, limit extremes
    stim_row_t stim_rows [] = '{
        '{4'd10, "",                VERDICT_ACCEPT},
        '{4'd10, "/",               VERDICT_ACCEPT},
        '{4'd10, "0:/",             VERDICT_ACCEPT},
        '{4'd10, "9:/",             VERDICT_ACCEPT},
        '{4'd10, "3:/DIR/FILE.TXT", VERDICT_ACCEPT},
        '{4'd10, "ABCDEFGH.XYZ",    VERDICT_ACCEPT},
        '{4'd10, "_-$~09/Z.1_",     VERDICT_ACCEPT},
        '{4'd10, "ABCDEFGHI",       VERDICT_REJECT},
        '{4'd10, "A.BCDE",          VERDICT_REJECT},
        '{4'd10, "1:B",             VERDICT_REJECT},
        '{4'd10, "0:",              VERDICT_PREDICT},
        '{4'd10, "1/2",             VERDICT_PREDICT},
        '{4'd10, "7",               VERDICT_PREDICT},
        '{4'd10, "//",              VERDICT_REJECT},
        '{4'd10, "A//B",            VERDICT_REJECT},
        '{4'd10, "A/",              VERDICT_REJECT},
        '{4'd10, "a",               VERDICT_REJECT},
        '{4'd10, ".A",              VERDICT_REJECT},
        '{4'd10, "A.B.C",           VERDICT_REJECT},
        '{4'd10, "A.",              VERDICT_REJECT},
        '{4'd10, "A\001 \177\200\377", VERDICT_REJECT},
        '{4'd0,  "0:/",             VERDICT_REJECT},
        '{4'd15, "9:/A",            VERDICT_ACCEPT},
        '{4'd5,  "5:/A",            VERDICT_REJECT},
        '{4'd5,  "4:/B/C.D",        VERDICT_PREDICT}
    };

    // limits of the random phases, extremes among them
    logic [3:0] phase_limits [5] = '{4'd10, 4'd0, 4'd15, 4'd3, 4'd10};

    // parser copy
    logic [3:0] dev_limit = DEVICE_LIMIT_RST;
    char_t      first_chars [2];
    logic [1:0] seen_count;
    phase_t     cur_phase;
    logic [3:0] stem_len;
    logic [2:0] ext_len;
    bit         dotted;
    bit         rejected;

    bit verdicts [$];     // verdicts still owed by the block
    int mismatches = 0;
    int idle_odds = 0;    // percent chance of a stall burst, 0 for none
    int hold_left = 0;
    int verdicts_seen = 0;

    short_name_path_validator_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_path();
        first_chars[0] = 8'd0;
        first_chars[1] = 8'd0;
        seen_count = 2'd0;
        cur_phase = PH_START;
        stem_len = 4'd0;
        ext_len = 3'd0;
        dotted = 1'b0;
        rejected = 1'b0;
    endfunction

    function automatic void start_component();
        stem_len = 4'd0;
        ext_len = 3'd0;
        dotted = 1'b0;
    endfunction

    function automatic bit legal_name_char(input char_t c);
        return (c >= "A" && c <= "Z") || (c >= CH_ZERO && c <= CH_NINE) ||
               c == "_" || c == "-" || c == "$" || c == "~";
    endfunction

    function automatic bit component_complete();
        return stem_len != 4'd0 && (!dotted || ext_len != 3'd0);
    endfunction

    // one non-slash, non-terminator byte into the current component
    function automatic void take_name_char(input char_t c);
        if (c == CH_DOT)
        begin
            if (dotted || stem_len == 4'd0)
                rejected = 1'b1;
            else
                dotted = 1'b1;
        end
        else if (!legal_name_char(c))
            rejected = 1'b1;
        else if (dotted)
        begin
            ext_len++;
            if (ext_len > MAX_EXT)
                rejected = 1'b1;
        end
        else
        begin
            stem_len++;
            if (stem_len > MAX_BASE)
                rejected = 1'b1;
        end
    endfunction

    // advances the parser copy by one accepted byte; done marks a verdict
    function automatic void step_path(input char_t c, output bit done, output bit ok);
        char_t drive;
        done = 1'b0;
        ok = 1'b0;
        if (c == CH_NUL)
        begin
            done = 1'b1;
            if (!rejected)
                case (cur_phase)
                    PH_START, PH_LOGICAL, PH_ROOT: ok = 1'b1;
                    PH_DIGIT, PH_COMP:             ok = component_complete();
                    default:                       ok = 1'b0;
                endcase
            clear_path();
            return;
        end
        if (seen_count < 2'd2)
            first_chars[seen_count[0]] = c;
        if (seen_count < 2'd3)
            seen_count++;
        if (rejected)
            return;
        case (cur_phase)
            PH_START:
            begin
                if (c == CH_SLASH)
                    cur_phase = PH_ROOT;
                else
                begin
                    start_component();
                    take_name_char(c);
                    cur_phase = (c >= CH_ZERO && c <= CH_NINE) ? PH_DIGIT : PH_COMP;
                end
            end
            PH_DIGIT:
            begin
                if (c == CH_COLON)
                    cur_phase = PH_COLON;
                else if (c == CH_SLASH)
                    cur_phase = PH_SEP;   // the digit was a whole component
                else
                begin
                    take_name_char(c);
                    cur_phase = PH_COMP;
                end
            end
            PH_COLON:
            begin
                if (c == CH_SLASH)
                begin
                    drive = first_chars[0] - CH_ZERO;
                    if (!(drive < dev_limit && drive <= MAX_DRIVE))
                        rejected = 1'b1;
                    cur_phase = PH_LOGICAL;
                end
                else
                    rejected = 1'b1;
            end
            PH_LOGICAL:
            begin
                if (c == CH_SLASH)
                    cur_phase = PH_ROOT;
                else
                begin
                    start_component();
                    take_name_char(c);
                    cur_phase = PH_COMP;
                end
            end
            PH_ROOT, PH_SEP:
            begin
                if (c == CH_SLASH)
                    rejected = 1'b1;
                else
                begin
                    start_component();
                    take_name_char(c);
                    cur_phase = PH_COMP;
                end
            end
            PH_COMP:
            begin
                if (c == CH_SLASH)
                begin
                    if (!component_complete())
                        rejected = 1'b1;
                    cur_phase = PH_SEP;
                end
                else
                    take_name_char(c);
            end
            default:
                rejected = 1'b1;
        endcase
    endfunction

    // sends one byte, with an optional gap ahead of it, and records the expected verdict on accept
    task automatic push_byte(input char_t c, input verdict_src_t how);
        int  gap;
        bit  done;
        bit  ok;
        if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        step_path(c, done, ok);
        if (done)
        begin
            if (how == VERDICT_PREDICT)
                verdicts.push_back(ok);
            else
                verdicts.push_back(how == VERDICT_ACCEPT);
        end
    endtask

    task automatic send_path(input char_t q [$], input verdict_src_t how);
        foreach (q[i])
            push_byte(q[i], how);
        push_byte(CH_NUL, how);
    endtask

    // sender holds off until every verdict is out and the parser has settled
    task automatic wait_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        wait_quiet();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        dev_limit = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic char_t any_name_char();
        return NAME_SET.getc($urandom_range(0, NAME_SET.len() - 1));
    endfunction

    // random path: mostly well formed, some broken, some pure noise
    function automatic void make_path(output char_t q [$]);
        int kind;
        int ncomp;
        int blen;
        int elen;
        int pos;
        bit prefixed;
        q = {};
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(0, 10))
                q.push_back(char_t'($urandom_range(1, 255)));
            return;
        end
        prefixed = ($urandom_range(0, 2) == 0);
        if (prefixed)
        begin
            q.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
            q.push_back(CH_COLON);
            q.push_back(CH_SLASH);
        end
        if ($urandom_range(0, prefixed ? 3 : 1) == 0)
            q.push_back(CH_SLASH);
        ncomp = $urandom_range(0, 3);
        for (int i = 0; i < ncomp; i++)
        begin
            if (i > 0)
                q.push_back(CH_SLASH);
            blen = ($urandom_range(0, 15) == 0) ? 9 : $urandom_range(1, 8);
            // a drive-like digit start now and then
            if ($urandom_range(0, 5) == 0)
                q.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
            else
                q.push_back(any_name_char());
            repeat (blen - 1)
                q.push_back(any_name_char());
            if ($urandom_range(0, 1) == 0)
            begin
                q.push_back(CH_DOT);
                elen = ($urandom_range(0, 11) == 0) ? 4 * $urandom_range(0, 1)
                                                    : $urandom_range(1, 3);
                repeat (elen)
                    q.push_back(any_name_char());
            end
        end
        if (kind <= 2)
        begin
            if (q.size() == 0)
                q.push_back(CH_SLASH);
            pos = $urandom_range(0, q.size() - 1);
            case ($urandom_range(0, 3))
                0: q[pos] = char_t'($urandom_range(1, 255));
                1: q.insert(pos, CH_SLASH);
                2: q.insert(pos, CH_DOT);
                default: q[pos] = "a" + char_t'($urandom_range(0, 25));
            endcase
        end
    endfunction

    // result side stalls in random bursts, at the odds set by idle_odds
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds)
        begin
            hold_left <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // verdict checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            verdicts_seen++;
            if (verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict word %02h at %0t", m_axis_tdata, $realtime);
            end
            else
            begin
                bit want;
                want = verdicts.pop_front();
                if (m_axis_tdata !== {7'd0, want})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict word mismatch: expected %02h got %02h at %0t",
                                 {7'd0, want}, m_axis_tdata, $realtime);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        char_t q [$];
        int    sent;
        int    base_seen;
        clear_path();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed paths
        idle_odds = 20;
        foreach (stim_rows[r])
        begin
            if (stim_rows[r].limit != dev_limit)
                write_limit(stim_rows[r].limit);
            q = {};
            for (int i = 0; i < stim_rows[r].text.len(); i++)
                q.push_back(stim_rows[r].text.getc(i));
            send_path(q, stim_rows[r].how);
        end

        // random phases, each under its own limit; first and last run without
        // stalls, the rest with bursts on both sides
        for (int p = 0; p < 5; p++)
        begin
            write_limit(phase_limits[p] == 4'd3 ? 4'($urandom_range(1, 9)) : phase_limits[p]);
            idle_odds = (p == 0 || p == 4) ? 0 : 30;
            sent = 0;
            base_seen = verdicts_seen + verdicts.size();
            while (sent < RANDOM_BYTES_PER_PHASE ||
                   verdicts_seen + verdicts.size() - base_seen < VERDICTS_PER_PHASE)
            begin
                make_path(q);
                send_path(q, VERDICT_PREDICT);
                sent += q.size() + 1;
            end
        end

        wait_quiet();
        repeat (5) @(posedge clk);
        mismatches += verdicts.size();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
